[sv/temporal_mean_blend_denoise_unit_defines.svh]
// Assertion macros used by the temporal mean blend denoiser RTL.
`ifndef TEMPORAL_MEAN_BLEND_DENOISE_UNIT_DEFINES_SVH
`define TEMPORAL_MEAN_BLEND_DENOISE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TMBD_ASSERT(lbl, prop) lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
    prop) else $error("tmbd assertion failed");
`define TMBD_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge aclk) prop) \
    else $error("tmbd reset assertion failed");
`else
`define TMBD_ASSERT(lbl, prop)
`define TMBD_ASSERT_RST(lbl, prop)
`endif
`endif

[sv/tmbd_pkg.sv]
// Shared types, constants and the reciprocal table of the temporal mean blend denoiser.
package tmbd_pkg;

    localparam int SIDE_FIELDS        = 4;
    localparam int DEFAULT_MAX_RADIUS = 4;
    localparam int PIX_W              = 8;
    localparam int PAIR_W             = PIX_W + 1;
    localparam int SUM_W              = 12;
    localparam int RECIP_SHIFT        = 16;
    localparam int RECIP_W            = RECIP_SHIFT + 1;
    localparam int PROD_W             = SUM_W + RECIP_W;
    localparam int RADIUS_W           = 3;
    localparam int STRENGTH_W         = 9;
    localparam int BLEND_W            = PIX_W + STRENGTH_W;
    localparam int MIX_W              = BLEND_W + 1;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;
    localparam int NUM_FIELDS         = 2 * SIDE_FIELDS + 1;
    localparam int S_TDATA_W          = NUM_FIELDS * PIX_W;
    localparam int M_TDATA_W          = PIX_W;

    localparam logic [RADIUS_W-1:0]   RADIUS_RESET   = 3'd1;
    localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 9'd128;
    localparam logic [STRENGTH_W-1:0] STRENGTH_ONE   = 9'd256;
    localparam logic [MIX_W-1:0]      ROUND_HALF     = 18'd128;
    localparam logic [MIX_W-1:0]      BLEND_MAX      = 18'd65280;
    localparam logic [PIX_W-1:0]      PIX_MAX        = 8'd255;

    typedef enum logic {
        REG_RADIUS   = 1'b0,
        REG_STRENGTH = 1'b1
    } reg_idx_t;

    // Registered lane results handed to the merging stage.
    typedef struct packed {
        logic [SIDE_FIELDS-1:0][PAIR_W-1:0] pair_sum;
        logic [PIX_W-1:0]                   cur;
        logic [RADIUS_W-1:0]                r_eff;
    } lane_out_t;

    // Ceiling of 2^16 / (2r+1); with sums below 2296 the product shifted
    // right by 16 gives the exact floor of the mean.
    function automatic logic [RECIP_W-1:0] recip_of_radius(input logic [RADIUS_W-1:0] r);
        logic [RECIP_W-1:0] m;
        case (r)
            3'd0:    m = 17'd65536;
            3'd1:    m = 17'd21846;
            3'd2:    m = 17'd13108;
            3'd3:    m = 17'd9363;
            3'd4:    m = 17'd7282;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

[sv/tmbd_lane.sv]
// One radius lane: adds the two samples at one frame distance when that distance is in use.
module tmbd_lane #(
    parameter int DIST = 1
) (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [tmbd_pkg::RADIUS_W-1:0] r_eff,
    input  logic [tmbd_pkg::PIX_W-1:0]    pix_back,
    input  logic [tmbd_pkg::PIX_W-1:0]    pix_ahead,
    output logic [tmbd_pkg::PAIR_W-1:0]   pair_sum_reg
);
    import tmbd_pkg::*;

    localparam logic [RADIUS_W-1:0] DIST_CODE = RADIUS_W'(DIST);

    logic [PAIR_W-1:0] pair_sum_next;

    always_comb begin
        if (r_eff >= DIST_CODE) begin
            pair_sum_next = {1'b0, pix_back} + {1'b0, pix_ahead};
        end else begin
            pair_sum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pair_sum_reg <= pair_sum_next;
        end
    end

endmodule

[sv/tmbd_merge.sv]
// Merging pipeline: total of the lanes, mean by reciprocal multiply, blend, round and clamp.
`include "temporal_mean_blend_denoise_unit_defines.svh"
module tmbd_merge (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tmbd_pkg::lane_out_t             lane_in,
    input  logic [tmbd_pkg::STRENGTH_W-1:0] blend_strength,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tmbd_pkg::M_TDATA_W-1:0]  m_tdata
);
    import tmbd_pkg::*;

    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    logic [SUM_W-1:0]   suma_reg, suma_next;
    logic [RECIP_W-1:0] recipa_reg;
    logic [PIX_W-1:0]   cura_reg, curb_reg;
    logic [PROD_W-1:0]  prodb_reg;
    logic [BLEND_W-1:0] pc_cur_reg, pc_avg_reg;
    logic [PIX_W-1:0]   avg;
    logic [STRENGTH_W-1:0] s_eff, s_inv;
    logic [MIX_W-1:0]   blend_sum;
    logic [MIX_W-1:0]   mix;
    logic [PIX_W-1:0]   pix_out_reg, pix_out_next;

    assign rdy_d    = !vd_reg || m_tready;
    assign rdy_c    = !vc_reg || rdy_d;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb begin
        suma_next = SUM_W'(lane_in.cur);
        for (int i = 0; i < SIDE_FIELDS; i++) begin
            suma_next = suma_next + SUM_W'(lane_in.pair_sum[i]);
        end
    end

    assign avg   = prodb_reg[RECIP_SHIFT +: PIX_W];
    assign s_eff = (blend_strength > STRENGTH_ONE) ? STRENGTH_ONE : blend_strength;
    assign s_inv = STRENGTH_ONE - s_eff;

    assign blend_sum = MIX_W'(pc_cur_reg) + MIX_W'(pc_avg_reg);
    assign mix       = (blend_sum + ROUND_HALF) >> 8;
    assign pix_out_next = (mix > MIX_W'(PIX_MAX)) ? PIX_MAX : mix[PIX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (rdy_a) va_reg <= in_valid;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
            if (rdy_d) vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            suma_reg   <= suma_next;
            recipa_reg <= recip_of_radius(lane_in.r_eff);
            cura_reg   <= lane_in.cur;
        end
        if (rdy_b && va_reg) begin
            prodb_reg <= PROD_W'(suma_reg) * PROD_W'(recipa_reg);
            curb_reg  <= cura_reg;
        end
        if (rdy_c && vb_reg) begin
            pc_cur_reg <= BLEND_W'(curb_reg) * BLEND_W'(s_inv);
            pc_avg_reg <= BLEND_W'(avg) * BLEND_W'(s_eff);
        end
        if (rdy_d && vc_reg) begin
            pix_out_reg <= pix_out_next;
        end
    end

    assign m_tvalid = vd_reg;
    assign m_tdata  = pix_out_reg;

    `TMBD_ASSERT_RST(a_reset_empties, !aresetn |=> !m_tvalid)
    `TMBD_ASSERT(a_mean_in_range, vb_reg |-> (prodb_reg[PROD_W-1:RECIP_SHIFT+PIX_W] == '0))
    `TMBD_ASSERT(a_blend_in_range, vc_reg |-> (blend_sum <= BLEND_MAX))
    `TMBD_ASSERT(a_stalled_item_kept, (vc_reg && !rdy_d) |=> vc_reg)

endmodule

[sv/temporal_mean_blend_denoise_unit.sv]
// Top level of the temporal mean blend denoiser: config registers, radius lanes, merge pipeline.
//
//  Channel   Dir  Handshake           Content
//  s_*       in   s_tvalid/s_tready   nine 8-bit samples of one pixel position
//  m_*       out  m_tvalid/m_tready   one denoised 8-bit pixel
//  APB       in   psel/penable        radius (0x0), blend_strength (0x4)
//
// One item enters per clock while s_tready is high; m_tvalid for a result rises when its item
// is loaded into the last stage. There are five register stages: the lane stage, loaded at the
// accepting edge, and four merge stages (total, reciprocal multiply, blend multiplies, round).
// Every stage holds its own valid bit, so items keep entering while a result waits
// for m_tready until the pipeline is full.
// Reset is synchronous on aresetn low; it empties the pipeline and loads the register defaults.
module temporal_mean_blend_denoise_unit #(
    parameter int MAX_RADIUS = tmbd_pkg::DEFAULT_MAX_RADIUS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // back4, back3, back2, back1, current, ahead1, ahead2, ahead3, ahead4 (8 bits each)
    input  logic [tmbd_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_out
    output logic [tmbd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tmbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tmbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tmbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tmbd_pkg::*;

    localparam int LANES = (MAX_RADIUS < SIDE_FIELDS) ? MAX_RADIUS : SIDE_FIELDS;
    localparam logic [RADIUS_W-1:0] LANES_CODE = RADIUS_W'(LANES);
    localparam int CENTER = SIDE_FIELDS;

    logic [RADIUS_W-1:0]   radius_reg;
    logic [STRENGTH_W-1:0] blend_strength_reg;
    logic [RADIUS_W-1:0]   r_eff;
    reg_idx_t              reg_idx;
    logic                  cfg_wr;

    logic                  v1_reg;
    logic                  rdy1;
    logic                  load;
    logic                  merge_ready;
    logic [PIX_W-1:0]      cur1_reg;
    logic [RADIUS_W-1:0]   r1_reg;
    lane_out_t             lane_out;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg         <= RADIUS_RESET;
            blend_strength_reg <= STRENGTH_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_RADIUS:   radius_reg         <= pwdata[RADIUS_W-1:0];
                REG_STRENGTH: blend_strength_reg <= pwdata[STRENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RADIUS:   prdata = APB_DATA_W'(radius_reg);
            REG_STRENGTH: prdata = APB_DATA_W'(blend_strength_reg);
            default:      prdata = '0;
        endcase
    end

    assign r_eff = (radius_reg > LANES_CODE) ? LANES_CODE : radius_reg;

    assign rdy1     = !v1_reg || merge_ready;
    assign s_tready = rdy1;
    assign load     = s_tvalid && rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur1_reg <= s_tdata[CENTER*PIX_W +: PIX_W];
            r1_reg   <= r_eff;
        end
    end

    for (genvar d = 1; d <= SIDE_FIELDS; d++) begin : g_lane
        if (d <= LANES) begin : g_used
            tmbd_lane #(
                .DIST (d)
            ) u_lane (
                .aclk         (aclk),
                .load         (load),
                .r_eff        (r_eff),
                .pix_back     (s_tdata[(CENTER-d)*PIX_W +: PIX_W]),
                .pix_ahead    (s_tdata[(CENTER+d)*PIX_W +: PIX_W]),
                .pair_sum_reg (lane_out.pair_sum[d-1])
            );
        end else begin : g_unused
            assign lane_out.pair_sum[d-1] = '0;
        end
    end

    assign lane_out.cur   = cur1_reg;
    assign lane_out.r_eff = r1_reg;

    tmbd_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (v1_reg),
        .in_ready       (merge_ready),
        .lane_in        (lane_out),
        .blend_strength (blend_strength_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

[tb/temporal_mean_blend_denoise_unit_test.sv]
// Self-checking stream testbench for the temporal mean blend denoiser with APB register setup.
module temporal_mean_blend_denoise_unit_test;
    import tmbd_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int SWEEP_ITEMS  = 95;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Register values as the block should currently hold them.
    logic [RADIUS_W-1:0]   cfg_radius   = RADIUS_RESET;
    logic [STRENGTH_W-1:0] cfg_strength = STRENGTH_RESET;

    logic [PIX_W-1:0] expected_pixels[$];
    logic [PIX_W-1:0] expected_pixel;
    int               mismatch_count  = 0;
    int               quiet_cycles    = 0;
    int               rx_wait         = 0;
    int               rx_hold_request = 0;
    bit               tx_gaps_on      = 1'b0;
    bit               rx_stalls_on    = 1'b0;

    temporal_mean_blend_denoise_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Floor of the mean over the frames within the radius, blended with the current sample.
    function automatic logic [PIX_W-1:0] denoise_pixel(input logic [S_TDATA_W-1:0] samples);
        int unsigned r;
        int unsigned cur;
        int unsigned sum;
        int unsigned avg;
        int unsigned s;
        int unsigned mix;
        r = (cfg_radius > SIDE_FIELDS) ? SIDE_FIELDS : cfg_radius;
        cur = samples[SIDE_FIELDS*PIX_W +: PIX_W];
        sum = cur;
        for (int d = 1; d <= int'(r); d++) begin
            sum += samples[(SIDE_FIELDS-d)*PIX_W +: PIX_W];
            sum += samples[(SIDE_FIELDS+d)*PIX_W +: PIX_W];
        end
        avg = sum / (2*r + 1);
        s = (cfg_strength > STRENGTH_ONE) ? STRENGTH_ONE : cfg_strength;
        mix = (cur*(256 - s) + avg*s + 128) >> 8;
        if (mix > PIX_MAX)
            mix = PIX_MAX;
        return mix[PIX_W-1:0];
    endfunction

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // All neighbors share one value, the current sample another.
    function automatic logic [S_TDATA_W-1:0] fill(input logic [PIX_W-1:0] side,
                                                 input logic [PIX_W-1:0] center);
        logic [S_TDATA_W-1:0] v;
        for (int k = 0; k < NUM_FIELDS; k++)
            v[k*PIX_W +: PIX_W] = (k == SIDE_FIELDS) ? center : side;
        return v;
    endfunction

    // Mix of uniform noise, smooth video-like areas and saturated content.
    function automatic logic [S_TDATA_W-1:0] random_samples();
        logic [S_TDATA_W-1:0] v;
        int style;
        int base;
        int val;
        style = $urandom_range(0, 3);
        base  = $urandom_range(0, 255);
        for (int k = 0; k < NUM_FIELDS; k++) begin
            case (style)
                2: begin
                    val = base + int'($urandom_range(0, 16)) - 8;
                    if (val < 0)
                        val = 0;
                    if (val > 255)
                        val = 255;
                end
                3: val = $urandom_range(0, 1) ? 255 - int'($urandom_range(0, 2))
                                              : int'($urandom_range(0, 2));
                default: val = $urandom_range(0, 255);
            endcase
            v[k*PIX_W +: PIX_W] = val[PIX_W-1:0];
        end
        return v;
    endfunction

    task automatic send_samples(input logic [S_TDATA_W-1:0] samples);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= samples;
        do @(posedge aclk); while (!s_tready);
        expected_pixels.push_back(denoise_pixel(samples));
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_RADIUS:   cfg_radius   = value[RADIUS_W-1:0];
            REG_STRENGTH: cfg_strength = value[STRENGTH_W-1:0];
            default: ;
        endcase
    endtask

    // Writes both registers once the pipeline is empty; high bits carry random junk.
    task automatic set_blend(input int radius_val, input int strength_val);
        wait_for_drain();
        write_register(REG_RADIUS, ($urandom & ~32'h7) | radius_val);
        @(posedge aclk);
        write_register(REG_STRENGTH, ($urandom & ~32'h1FF) | strength_val);
    endtask

    task automatic test_reset_defaults();
        send_samples(fill(8'h00, 8'h00));
        send_samples(fill(8'hFF, 8'hFF));
        send_samples(72'h00_00_00_FF_00_FF_00_00_00);
    endtask

    task automatic test_full_mean_and_bypass();
        set_blend(4, 256);
        send_samples(fill(8'hFF, 8'hFF));
        send_samples(fill(8'hFF, 8'h00));
        send_samples(fill(8'h00, 8'hFF));
        send_samples(72'hFF_00_FF_00_FF_00_FF_00_FF);
        send_samples(72'h00_FF_00_FF_00_FF_00_FF_00);
        set_blend(4, 0);
        send_samples(fill(8'hFF, 8'h00));
        send_samples(fill(8'h00, 8'hFF));
    endtask

    task automatic test_radius_zero();
        set_blend(0, 256);
        send_samples(fill(8'hFF, 8'h00));
        send_samples(72'h12_34_56_78_9A_BC_DE_F0_11);
    endtask

    // Radius values beyond four must behave as four.
    task automatic test_radius_saturation();
        set_blend(5, 256);
        send_samples(fill(8'hFF, 8'h00));
        send_samples(72'h01_80_FF_7F_03_FE_40_C0_10);
        set_blend(7, 200);
        send_samples(fill(8'h00, 8'hFF));
        send_samples(72'hFF_01_02_03_80_FD_FE_00_55);
    endtask

    // Strength values above one act as the full mean.
    task automatic test_strength_saturation();
        set_blend(2, 257);
        send_samples(fill(8'hC8, 8'h0A));
        send_samples(72'h00_00_FF_FF_01_FF_FF_00_00);
        set_blend(3, 511);
        send_samples(fill(8'h0A, 8'hC8));
        send_samples(72'hFF_00_FE_01_7F_02_FD_03_FC);
    endtask

    task automatic test_random_sweep();
        int strengths[8] = '{0, 256, 511, 1, 128, 255, 257, 0};
        strengths[7] = $urandom_range(0, 511);
        for (int phase = 0; phase < 8; phase++) begin
            set_blend(phase, strengths[phase]);
            tx_gaps_on   = (phase % 3) != 0;
            rx_stalls_on = (phase % 3) != 0;
            repeat (SWEEP_ITEMS) send_samples(random_samples());
        end
    endtask

    // The receiver stops for a long stretch while items keep coming, so the input stalls.
    task automatic test_output_backpressure();
        set_blend(4, $urandom_range(0, 256));
        tx_gaps_on      = 1'b0;
        rx_stalls_on    = 1'b1;
        rx_hold_request = HOLD_CYCLES;
        repeat (60) send_samples(random_samples());
    endtask

    always @(posedge aclk) begin
        if (rx_hold_request != 0) begin
            rx_wait = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else begin
            m_tready <= 1'b1;
            if (rx_stalls_on)
                rx_wait = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual pixel_out %0d",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                expected_pixel = expected_pixels.pop_front();
                if (m_tdata !== expected_pixel) begin
                    $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                             $time, expected_pixel, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("temporal_mean_blend_denoise_unit_test failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_full_mean_and_bypass();
        test_radius_zero();
        test_radius_saturation();
        test_strength_saturation();
        test_random_sweep();
        test_output_backpressure();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("temporal_mean_blend_denoise_unit_test passed");
        else
            $display("temporal_mean_blend_denoise_unit_test failed");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/tmbd_pkg.sv
sv/tmbd_lane.sv
sv/tmbd_merge.sv
sv/temporal_mean_blend_denoise_unit.sv
tb/temporal_mean_blend_denoise_unit_test.sv
